// ===== sv/smp_pkg.sv =====
// Shared constants, codes and word types for the steering module homing and aim block.
package smp_pkg;

   // Fixed point format of all angles and speeds.
   localparam int FRAC_BITS   = 16;
   localparam int SCALE_SHIFT = 30 - FRAC_BITS;

   // Angle constants, rounded from Q2.30 values.
   localparam longint PI_FX      = (64'sd3373259426 + (64'sd1 <<< (SCALE_SHIFT - 1)))
                                   >>> SCALE_SHIFT;
   localparam longint TWO_PI_FX  = (64'sd6746518852 + (64'sd1 <<< (SCALE_SHIFT - 1)))
                                   >>> SCALE_SHIFT;
   localparam longint HALF_PI_FX = (64'sd1686629713 + (64'sd1 <<< (SCALE_SHIFT - 1)))
                                   >>> SCALE_SHIFT;

   // Reciprocal of the fixed point two pi for the quotient estimate, scaled by 2^32.
   localparam longint RECIP     = (64'sd1 <<< 32) / TWO_PI_FX;
   localparam int     RCW       = $clog2(RECIP + 1);
   // Width of the largest quotient of a 32 bit magnitude by two pi.
   localparam int     QW        = $clog2(((64'sd1 <<< 31) / TWO_PI_FX) + 1);
   // Remainder width, the remainder stays below two pi.
   localparam int     RW        = $clog2(TWO_PI_FX);
   // Width of headings, targets and heading errors.
   localparam int     AW        = ((RW > 19) ? RW : 19) + 3;
   // Width of the position command sum before saturation.
   localparam int     SUMW      = ((AW > 32) ? AW : 32) + 1;

   // Input operation codes.
   localparam logic [2:0] OP_TICK = 3'd0;
   localparam logic [2:0] OP_CAL  = 3'd1;
   localparam logic [2:0] OP_RUN  = 3'd2;
   localparam logic [2:0] OP_AIM  = 3'd3;
   localparam logic [2:0] OP_STOP = 3'd4;

   // Steering motor commands.
   localparam logic [1:0] STEER_NONE  = 2'd0;
   localparam logic [1:0] STEER_SPEED = 2'd1;
   localparam logic [1:0] STEER_POS   = 2'd2;
   localparam logic [1:0] STEER_ZERO  = 2'd3;

   // Drive motor commands.
   localparam logic [1:0] MAIN_NONE  = 2'd0;
   localparam logic [1:0] MAIN_DRIVE = 2'd1;
   localparam logic [1:0] MAIN_BRAKE = 2'd2;

   // Mode codes as reported on the result word.
   localparam logic [1:0] MODE_CODE_STOP = 2'd0;
   localparam logic [1:0] MODE_CODE_CAL  = 2'd1;
   localparam logic [1:0] MODE_CODE_RUN  = 2'd2;
   localparam logic [1:0] MODE_CODE_AIM  = 2'd3;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEEK_SPEED      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_TOLERANCE = 3'd3;

   typedef enum logic [3:0] {
      MODE_STOP = 4'b0001,
      MODE_CAL  = 4'b0010,
      MODE_RUN  = 4'b0100,
      MODE_AIM  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [2:0]         op;
      logic               switch_hit;
      logic signed [31:0] rotation_pos;
      logic signed [18:0] target_heading;
      logic signed [31:0] target_speed;
   } item_type;

   typedef struct packed {
      logic signed [31:0] seek_speed;
      logic [9:0]         backoff_limit;
      logic [6:0]         settle_ticks;
      logic [16:0]        align_tolerance;
   } cfg_type;

   typedef struct packed {
      item_type          item;
      logic [RW-1:0]     rem;
   } wrap_type;

   typedef struct packed {
      logic [2:0]         op;
      logic               switch_hit;
      logic signed [31:0] pos_cmd;
      logic signed [31:0] speed;
      logic               ok;
   } aim_type;

endpackage

// ===== sv/smp_wrap.sv =====
// Three stage pipeline that reduces the steering position modulo two pi.
module smp_wrap
   import smp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output wrap_type out_word
);

   logic [2:0]          vld_ff;
   logic [2:0]          vld_in;
   logic [3:0]          rdy;

   item_type            item1_ff;
   logic [31:0]         abs1_ff;
   logic [QW-1:0]       q1_ff;
   item_type            item2_ff;
   logic [31:0]         abs2_ff;
   logic [31:0]         qc2_ff;
   wrap_type            out_ff;

   logic [31:0]         abs_in;
   logic [63:0]         qprod;
   logic [31:0]         qc_in;
   logic [32:0]         rem0;
   logic [32:0]         remm;
   wrap_type            out_in;

   // A stage takes a new word when it is empty or its successor moves.
   always_comb begin
      rdy[3] = out_ready;
      for (int i = 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[0] = rdy[0] ? in_valid  : vld_ff[0];
      vld_in[1] = rdy[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = rdy[2] ? vld_ff[1] : vld_ff[2];
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[2];
   assign out_word  = out_ff;

   // Quotient estimate is the true quotient or one below it.
   always_comb begin
      abs_in = in_item.rotation_pos[31] ? 32'(-in_item.rotation_pos)
                                        : 32'(in_item.rotation_pos);
      qprod  = 64'(abs_in) * 64'(RECIP);
      qc_in  = 32'(64'(q1_ff) * 64'(TWO_PI_FX));
      rem0   = {1'b0, abs2_ff} - {1'b0, qc2_ff};
      remm   = rem0 - 33'(TWO_PI_FX);
      out_in.item = item2_ff;
      out_in.rem  = remm[32] ? RW'(rem0) : RW'(remm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         item1_ff <= in_item;
         abs1_ff  <= abs_in;
         q1_ff    <= qprod[32 +: QW];
      end
      if (rdy[1]) begin
         item2_ff <= item1_ff;
         abs2_ff  <= abs1_ff;
         qc2_ff   <= qc_in;
      end
      if (rdy[2]) begin
         out_ff <= out_in;
      end
   end

   // The corrected remainder is always below two pi.
   a_rem_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> ({1'b0, out_ff.rem} < (RW+1)'(TWO_PI_FX)))
      else $error("wrapped remainder not below two pi");

endmodule

// ===== sv/smp_aim.sv =====
// Three stage pipeline that picks direct or reversed alignment and builds the position command.
module smp_aim
   import smp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [16:0] align_tolerance,
   input  logic        in_valid,
   output logic        in_ready,
   input  wrap_type    in_word,
   output logic        out_valid,
   input  logic        out_ready,
   output aim_type     out_word
);

   localparam logic signed [AW-1:0] PI_A   = AW'(PI_FX);
   localparam logic signed [AW-1:0] TWO_A  = AW'(TWO_PI_FX);
   localparam logic signed [AW-1:0] HALF_A = AW'(HALF_PI_FX);

   logic [2:0]             vld_ff;
   logic [2:0]             vld_in;
   logic [3:0]             rdy;

   // First stage: headings and targets.
   logic [2:0]             op1_ff;
   logic                   sw1_ff;
   logic signed [31:0]     pos1_ff;
   logic signed [31:0]     spd1_ff;
   logic signed [AW-1:0]   d0_ff, d1_ff, t0_ff, t1_ff;
   // Second stage: chosen error.
   logic [2:0]             op2_ff;
   logic                   sw2_ff;
   logic signed [31:0]     pos2_ff;
   logic signed [31:0]     spd2_ff;
   logic signed [AW-1:0]   err_ff;
   logic                   flip_ff;
   aim_type                out_ff;

   logic signed [AW-1:0]   rem_a;
   logic signed [AW-1:0]   tgt_a;
   logic signed [AW-1:0]   d0_in, d1_in, t1_in;
   logic signed [AW-1:0]   e00, e01, e10, e11;
   logic signed [AW-1:0]   err_in;
   logic                   flip_in;
   logic signed [SUMW-1:0] sum;
   logic signed [AW-1:0]   tol_a;
   aim_type                out_in;

   function automatic logic near(input logic signed [AW-1:0] e);
      near = (e < HALF_A) && (e > -HALF_A);
   endfunction

   always_comb begin
      rdy[3] = out_ready;
      for (int i = 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[0] = rdy[0] ? in_valid  : vld_ff[0];
      vld_in[1] = rdy[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = rdy[2] ? vld_ff[1] : vld_ff[2];
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[2];
   assign out_word  = out_ff;

   // Each heading candidate is the remainder or its negation plus a constant, so all are formed
   // side by side and selected by the sign of the position and by whether the remainder exceeds pi.
   always_comb begin
      rem_a = signed'({{(AW-RW){1'b0}}, in_word.rem});
      tgt_a = AW'(in_word.item.target_heading);
      if (!in_word.item.rotation_pos[31]) begin
         if (rem_a > PI_A) begin
            d0_in = rem_a - TWO_A;
            d1_in = rem_a - TWO_A + PI_A;
         end else begin
            d0_in = rem_a;
            d1_in = rem_a - PI_A;
         end
      end else begin
         d0_in = -rem_a;
         d1_in = (rem_a == '0) ? -PI_A : PI_A - rem_a;
      end
      t1_in = (tgt_a > 0) ? tgt_a - TWO_A : tgt_a + TWO_A;
   end

   // The first candidate within a quarter turn wins; if none is, the last one tried
   // stands and the speed keeps its sign.
   always_comb begin
      e00 = t0_ff - d0_ff;
      e01 = t0_ff - d1_ff;
      e10 = t1_ff - d0_ff;
      e11 = t1_ff - d1_ff;
      flip_in = 1'b0;
      if (near(e00)) begin
         err_in = e00;
      end else if (near(e01)) begin
         err_in  = e01;
         flip_in = 1'b1;
      end else if (near(e10)) begin
         err_in = e10;
      end else begin
         err_in  = e11;
         flip_in = near(e11);
      end
   end

   always_comb begin
      sum   = SUMW'(pos2_ff) + SUMW'(err_ff);
      tol_a = signed'({{(AW-17){1'b0}}, align_tolerance});
      out_in.op         = op2_ff;
      out_in.switch_hit = sw2_ff;
      if (sum > SUMW'(32'sh7FFFFFFF)) begin
         out_in.pos_cmd = 32'sh7FFFFFFF;
      end else if (sum < SUMW'(-33'sh080000000)) begin
         out_in.pos_cmd = 32'sh80000000;
      end else begin
         out_in.pos_cmd = 32'(sum);
      end
      if (!flip_ff) begin
         out_in.speed = spd2_ff;
      end else if (spd2_ff == 32'sh80000000) begin
         out_in.speed = 32'sh7FFFFFFF;
      end else begin
         out_in.speed = -spd2_ff;
      end
      out_in.ok = (err_ff < tol_a) && (err_ff > -tol_a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         op1_ff  <= in_word.item.op;
         sw1_ff  <= in_word.item.switch_hit;
         pos1_ff <= in_word.item.rotation_pos;
         spd1_ff <= in_word.item.target_speed;
         d0_ff   <= d0_in;
         d1_ff   <= d1_in;
         t0_ff   <= tgt_a;
         t1_ff   <= t1_in;
      end
      if (rdy[1]) begin
         op2_ff  <= op1_ff;
         sw2_ff  <= sw1_ff;
         pos2_ff <= pos1_ff;
         spd2_ff <= spd1_ff;
         err_ff  <= err_in;
         flip_ff <= flip_in;
      end
      if (rdy[2]) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== sv/smp_ctrl.sv =====
// Mode and calibration sequencer with the result register.
module smp_ctrl
   import smp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  aim_type            in_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_steer_cmd,
   output logic signed [31:0] rsp_steer_value,
   output logic [1:0]         rsp_main_cmd,
   output logic signed [31:0] rsp_main_speed,
   output logic [1:0]         rsp_mode_now,
   output logic               rsp_calibration_done,
   output logic               rsp_aligned
);

   // x / 5 for a 32 bit magnitude is (x * DIV5_MAGIC) >> DIV5_SHIFT.
   localparam logic [31:0] DIV5_MAGIC = 32'hCCCCCCCD;
   localparam int          DIV5_SHIFT = 34;

   mode_type           mode_ff, mode_in, mode_eff;
   logic signed [10:0] stage_ff, stage_in;
   logic               latch_ff, latch_in, latch_now;
   logic               rsp_valid_ff;

   logic [63:0]        bprod_ff;
   logic               bneg_ff;
   logic signed [31:0] back_ff;
   logic [31:0]        seek_abs;

   logic [1:0]         steer_cmd_ff, steer_cmd_in;
   logic signed [31:0] steer_val_ff, steer_val_in;
   logic [1:0]         main_cmd_ff, main_cmd_in;
   logic signed [31:0] main_spd_ff, main_spd_in;
   logic [1:0]         mode_code_ff, mode_code_in;
   logic               done_ff, done_in;
   logic               al_ff, al_in;

   logic               fire;
   logic signed [11:0] stage_x, limit_x, settle_x;

   // Back-off speed is derived from the seek speed through the product register and then the back-off register.
   always_comb begin
      seek_abs = cfg.seek_speed[31] ? 32'(-cfg.seek_speed) : 32'(cfg.seek_speed);
   end

   always_ff @(posedge clock) begin
      bprod_ff <= 64'(seek_abs) * 64'(DIV5_MAGIC);
      bneg_ff  <= cfg.seek_speed[31];
      back_ff  <= bneg_ff ? 32'(bprod_ff[63:DIV5_SHIFT])
                          : -32'(bprod_ff[63:DIV5_SHIFT]);
   end

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      mode_eff = mode_ff;
      case (in_word.op)
         OP_CAL:  mode_eff = MODE_CAL;
         OP_RUN:  mode_eff = MODE_RUN;
         OP_AIM:  mode_eff = MODE_AIM;
         OP_STOP: mode_eff = MODE_STOP;
         default: mode_eff = mode_ff;
      endcase
      latch_now = latch_ff || in_word.switch_hit;

      stage_x  = 12'(stage_ff);
      limit_x  = signed'({2'b00, cfg.backoff_limit});
      settle_x = -signed'({5'b00000, cfg.settle_ticks});

      mode_in      = mode_eff;
      stage_in     = stage_ff;
      latch_in     = latch_now;
      steer_cmd_in = STEER_NONE;
      steer_val_in = '0;
      main_cmd_in  = MAIN_NONE;
      main_spd_in  = '0;
      done_in      = 1'b0;
      al_in        = 1'b0;

      case (mode_eff)
         MODE_CAL: begin
            if (stage_x == '0) begin
               // Seeking the switch.
               steer_cmd_in = STEER_SPEED;
               if (latch_now) begin
                  steer_val_in = back_ff;
                  latch_in     = 1'b0;
                  stage_in     = 11'sd1;
               end else begin
                  steer_val_in = cfg.seek_speed;
               end
            end else if (stage_x > 0 && stage_x < limit_x) begin
               // Backing off until the switch fires again.
               steer_cmd_in = STEER_SPEED;
               if (latch_now) begin
                  latch_in = 1'b0;
                  stage_in = -11'sd1;
               end else begin
                  stage_in     = stage_ff + 11'sd1;
                  steer_val_in = back_ff;
               end
            end else if (stage_x > 0) begin
               // Back-off ran out, start seeking again.
               stage_in = '0;
            end else if (stage_x > settle_x) begin
               stage_in     = stage_ff - 11'sd1;
               steer_cmd_in = STEER_SPEED;
            end else begin
               steer_cmd_in = STEER_ZERO;
               stage_in     = '0;
               done_in      = 1'b1;
               mode_in      = MODE_STOP;
            end
         end
         MODE_RUN: begin
            steer_cmd_in = STEER_POS;
            steer_val_in = in_word.pos_cmd;
            al_in        = in_word.ok;
            if (in_word.ok) begin
               main_cmd_in = MAIN_DRIVE;
               main_spd_in = in_word.speed;
            end
         end
         MODE_AIM: begin
            steer_cmd_in = STEER_POS;
            steer_val_in = in_word.pos_cmd;
            al_in        = in_word.ok;
            if (in_word.ok) begin
               mode_in = MODE_STOP;
            end
         end
         default: begin
            steer_cmd_in = STEER_SPEED;
            main_cmd_in  = MAIN_BRAKE;
            mode_in      = MODE_STOP;
         end
      endcase

      case (mode_in)
         MODE_CAL: mode_code_in = MODE_CODE_CAL;
         MODE_RUN: mode_code_in = MODE_CODE_RUN;
         MODE_AIM: mode_code_in = MODE_CODE_AIM;
         default:  mode_code_in = MODE_CODE_STOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STOP;
         stage_ff     <= '0;
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            mode_ff  <= mode_in;
            stage_ff <= stage_in;
            latch_ff <= latch_in;
         end
         if (in_ready) begin
            rsp_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         steer_cmd_ff <= steer_cmd_in;
         steer_val_ff <= steer_val_in;
         main_cmd_ff  <= main_cmd_in;
         main_spd_ff  <= main_spd_in;
         mode_code_ff <= mode_code_in;
         done_ff      <= done_in;
         al_ff        <= al_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_steer_cmd        = steer_cmd_ff;
   assign rsp_steer_value      = steer_val_ff;
   assign rsp_main_cmd         = main_cmd_ff;
   assign rsp_main_speed       = main_spd_ff;
   assign rsp_mode_now         = mode_code_ff;
   assign rsp_calibration_done = done_ff;
   assign rsp_aligned          = al_ff;

   a_fire_shows : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted word did not reach the result register");

   a_done_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |->
         (steer_cmd_ff == STEER_ZERO && mode_code_ff == MODE_CODE_STOP))
      else $error("calibration done without encoder zero and stop");

   a_drive_aligned : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && main_cmd_ff == MAIN_DRIVE) |->
         (al_ff && mode_code_ff == MODE_CODE_RUN && steer_cmd_ff == STEER_POS))
      else $error("drive commanded while not aligned in run mode");

endmodule

// ===== sv/steering_module_homing_and_aim.sv =====
// Top level of the swerve steering module: homing calibration and heading aim.
//
//  channel | ports                                  | moves
//  --------+----------------------------------------+--------------------------------
//  req     | req_valid / req_ready + five fields    | one control tick word in
//  rsp     | rsp_valid / rsp_ready + seven fields   | one command word out per tick
//  csr     | csr_valid / csr_ready, index, data     | one register write word
//
// Every accepted word yields exactly one result word, and a new word can be accepted on
// every cycle unless rsp_ready stalls the pipeline. Words pass through the pipeline:
// input register, three stages of the modulo two pi reduction (quotient estimate,
// constant multiply, remainder correction), three aim stages and the result register.
// The stall is per stage: a stage refills whenever it is empty or its successor moves,
// so up to eight words can be in flight while rsp_ready is low.
// Reset is synchronous and active high; it returns the mode to stop, clears the
// calibration stage and switch latch, empties the pipeline and restores the registers.
// csr_ready is always high.
module steering_module_homing_and_aim
   import smp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Tick words.
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_op,
   input  logic                 req_switch_hit,
   input  logic signed [31:0]   req_rotation_pos,
   input  logic signed [18:0]   req_target_heading,
   input  logic signed [31:0]   req_target_speed,
   // Command words.
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_steer_cmd,
   output logic signed [31:0]   rsp_steer_value,
   output logic [1:0]           rsp_main_cmd,
   output logic signed [31:0]   rsp_main_speed,
   output logic [1:0]           rsp_mode_now,
   output logic                 rsp_calibration_done,
   output logic                 rsp_aligned,
   // Register writes.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   // Configuration registers. Writes are to arrive only while the block is idle (the block
   // itself does not enforce this), so the values feed the pipeline directly.
   cfg_type  cfg_ff;
   cfg_type  cfg_in;

   // Input register holding one accepted tick word.
   logic     in_vld_ff;
   item_type in_item_ff;
   item_type req_item;

   logic     wrap_in_ready;
   logic     wrap_valid;
   wrap_type wrap_word;
   logic     aim_in_ready;
   logic     aim_valid;
   aim_type  aim_word;
   logic     ctrl_in_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SEEK_SPEED:      cfg_in.seek_speed      = signed'(csr_data);
            CSR_BACKOFF_LIMIT:   cfg_in.backoff_limit   = csr_data[9:0];
            CSR_SETTLE_TICKS:    cfg_in.settle_ticks    = csr_data[6:0];
            CSR_ALIGN_TOLERANCE: cfg_in.align_tolerance = csr_data[16:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seek_speed      <= '0;
         cfg_ff.backoff_limit   <= 10'd1000;
         cfg_ff.settle_ticks    <= 7'd100;
         cfg_ff.align_tolerance <= 17'd3277;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The input register refills as soon as the wrap pipeline takes its word.
   assign req_ready = !in_vld_ff || wrap_in_ready;

   always_comb begin
      req_item.op             = req_op;
      req_item.switch_hit     = req_switch_hit;
      req_item.rotation_pos   = req_rotation_pos;
      req_item.target_heading = req_target_heading;
      req_item.target_speed   = req_target_speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_item_ff <= req_item;
      end
   end

   // Position reduced modulo two pi.
   smp_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_vld_ff),
      .in_ready  (wrap_in_ready),
      .in_item   (in_item_ff),
      .out_valid (wrap_valid),
      .out_ready (aim_in_ready),
      .out_word  (wrap_word)
   );

   // Alignment choice, position command and tolerance check. These depend only on the word
   // and the alignment tolerance, so they run for every word and the sequencer picks what it needs.
   smp_aim u_aim (
      .clock           (clock),
      .reset           (reset),
      .align_tolerance (cfg_ff.align_tolerance),
      .in_valid        (wrap_valid),
      .in_ready        (aim_in_ready),
      .in_word         (wrap_word),
      .out_valid       (aim_valid),
      .out_ready       (ctrl_in_ready),
      .out_word        (aim_word)
   );

   // Mode and calibration state, applied in word order at the result register.
   smp_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .in_valid             (aim_valid),
      .in_ready             (ctrl_in_ready),
      .in_word              (aim_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_steer_cmd        (rsp_steer_cmd),
      .rsp_steer_value      (rsp_steer_value),
      .rsp_main_cmd         (rsp_main_cmd),
      .rsp_main_speed       (rsp_main_speed),
      .rsp_mode_now         (rsp_mode_now),
      .rsp_calibration_done (rsp_calibration_done),
      .rsp_aligned          (rsp_aligned)
   );

endmodule
